// ===== rtl/core/grte_pkg.sv =====
package grte_pkg;

   localparam int GridWDefault = 128;
   localparam int GridHDefault = 128;

   localparam logic [1:0] StatusWrite = 2'd0;
   localparam logic [1:0] StatusEdge  = 2'd1;
   localparam logic [1:0] StatusLeft  = 2'd2;
   localparam logic [1:0] StatusZero  = 2'd3;

   localparam logic OpWrite = 1'b0;
   localparam logic OpRay   = 1'b1;

   localparam logic [1:0] CsrGridWidth  = 2'd0;
   localparam logic [1:0] CsrGridHeight = 2'd1;
   localparam logic [1:0] CsrPixelSize  = 2'd2;

   typedef struct packed {
      logic        op;
      logic [6:0]  pixel_x;
      logic [6:0]  pixel_y;
      logic [31:0] pixel_color;
      logic signed [23:0] start_x;
      logic signed [23:0] start_y;
      logic signed [23:0] dir_x;
      logic signed [23:0] dir_y;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] end_x;
      logic [6:0] end_y;
   } rsp_type;

   // unsigned divider handshake
   typedef struct packed {
      logic        start;
      logic [47:0] num;
      logic [23:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quo;
      logic [23:0] rem;
   } div_rsp_type;

endpackage

// ===== rtl/core/grte_div.sv =====
module grte_div (
   input  logic                  clock,
   input  logic                  reset,
   input  grte_pkg::div_req_type div_req,
   output grte_pkg::div_rsp_type div_rsp
);
   import grte_pkg::*;

   logic [47:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [25:0] shifted;

   // restoring division, one quotient bit a cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[47]};
      if (div_req.start) begin
         quo_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted[25:0] >= {2'b0, den_ff}) begin
            rem_in = shifted[24:0] - {1'b0, den_ff};
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted[24:0];
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff[23:0];

endmodule

// ===== rtl/core/grte_map.sv =====
module grte_map #(
   parameter int GRID_W = grte_pkg::GridWDefault,
   parameter int GRID_H = grte_pkg::GridHDefault,
   localparam int AddrW = $clog2(GRID_W * GRID_H)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic             wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic             rd_data
);
   import grte_pkg::*;

   logic mem_ff [GRID_W*GRID_H];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/grid_ray_to_edge_pixel.sv =====
// sequence: a write passes S_WR and S_OUT before its result strobe; a ray runs the two serial
// start divides, then per cell a check state, a read and a read-wait state per probe in the
// grid and only the read state outside, and per step the two multiplies, then a divide
// throughput: one item at a time, busy is high from leaving idle through the result strobe
// reset: synchronous active high, grid_width/grid_height 100, pixel_size 256, map kept
// the receiver cannot stall: rsp_valid lasts one cycle
module grid_ray_to_edge_pixel #(
   parameter int GRID_W = grte_pkg::GridWDefault,
   parameter int GRID_H = grte_pkg::GridHDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  grte_pkg::req_type req_data,
   output logic              rsp_valid,
   output grte_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import grte_pkg::*;

   localparam int XW    = $clog2(GRID_W);
   localparam int YW    = $clog2(GRID_H);
   localparam int AddrW = $clog2(GRID_W * GRID_H);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_WR    = 11'b00000000010,
      S_DIVX  = 11'b00000000100,
      S_DIVY  = 11'b00000001000,
      S_CHK   = 11'b00000010000,
      S_RD    = 11'b00000100000,
      S_RDW   = 11'b00001000000,
      S_STEP  = 11'b00010000000,
      S_MOVE  = 11'b00100000000,
      S_DIVW  = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  gw_ff, gh_ff;
   logic [15:0] ps_ff;
   req_type     req_ff, req_in;
   logic signed [25:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [24:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [2:0]  nb_ff, nb_in;
   logic        stepx_ff, stepx_in;
   logic [47:0] prodx_ff, prodx_in, prody_ff, prody_in;
   logic        mulph_ff, mulph_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [15:0] ps_eff;
   logic [24:0] psq;
   logic [10:0] ew, eh;
   logic [23:0] ax, ay;
   logic [24:0] xd, yd;
   logic signed [25:0] px, py;
   logic        out_cell, map_wr, wr_fill;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic        rd_data;
   logic        zero_dir;
   logic [23:0] remd;
   logic signed [25:0] q_floor;

   assign ps_eff = (ps_ff == 16'd0) ? 16'd1 : ps_ff;
   assign psq    = {1'b0, ps_eff, 8'd0};
   assign ew = ({3'b0, gw_ff} > 11'(GRID_W)) ? 11'(GRID_W) : {3'b0, gw_ff};
   assign eh = ({3'b0, gh_ff} > 11'(GRID_H)) ? 11'(GRID_H) : {3'b0, gh_ff};
   assign ax = req_ff.dir_x[23] ? 24'(-req_ff.dir_x) : req_ff.dir_x;
   assign ay = req_ff.dir_y[23] ? 24'(-req_ff.dir_y) : req_ff.dir_y;
   assign xd = req_ff.dir_x[23] ? ox_ff : ((req_ff.dir_x != '0) ? psq - ox_ff : '0);
   assign yd = req_ff.dir_y[23] ? oy_ff : ((req_ff.dir_y != '0) ? psq - oy_ff : '0);
   assign zero_dir = (req_ff.dir_x == '0) && (req_ff.dir_y == '0);

   // probe cell: 0 centre, then up, right, down, left
   always_comb begin
      px = cx_ff;
      py = cy_ff;
      unique case (nb_ff)
         3'd1: py = cy_ff - 26'sd1;
         3'd2: px = cx_ff + 26'sd1;
         3'd3: py = cy_ff + 26'sd1;
         3'd4: px = cx_ff - 26'sd1;
         default: ;
      endcase
   end
   assign out_cell = px[25] || py[25] || (px >= $signed({15'b0, ew}))
                     || (py >= $signed({15'b0, eh}));
   assign rd_addr  = AddrW'(py[YW-1:0]) * AddrW'(GRID_W) + AddrW'(px[XW-1:0]);

   assign wr_fill = (req_ff.pixel_color[23:0] != '0) && (req_ff.pixel_color[31:24] != '0);
   assign map_wr  = (state_ff == S_WR) && ({4'b0, req_ff.pixel_x} < 11'(GRID_W))
                    && ({4'b0, req_ff.pixel_y} < 11'(GRID_H));
   assign wr_addr = AddrW'(req_ff.pixel_y) * AddrW'(GRID_W) + AddrW'(req_ff.pixel_x);

   grte_map #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_map (
      .clock  (clock),
      .wr_en  (map_wr),
      .wr_addr(wr_addr),
      .wr_data(wr_fill),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   grte_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   // floor division of a start coordinate from unsigned quotient
   logic signed [23:0] s_cur;
   assign s_cur = (state_ff == S_DIVX) ? req_ff.start_x : req_ff.start_y;
   assign remd  = div_rsp.rem;
   always_comb begin
      if (s_cur[23]) begin
         q_floor = -$signed({1'b0, div_rsp.quo[24:0]});
         if (remd != '0) q_floor = q_floor - 26'sd1;
      end else begin
         q_floor = $signed({1'b0, div_rsp.quo[24:0]});
      end
   end
   // offset = (s - q*ps) * 256, equals rem or ps-rem
   logic [24:0] off_start;
   assign off_start = (s_cur[23] && remd != '0) ?
                      {1'b0, 16'(ps_eff - remd[15:0]), 8'd0} : {1'b0, remd[15:0], 8'd0};

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      cx_in = cx_ff; cy_in = cy_ff; ox_in = ox_ff; oy_in = oy_ff;
      nb_in = nb_ff; stepx_in = stepx_ff;
      prodx_in = prodx_ff; prody_in = prody_ff; mulph_in = mulph_ff;
      rsp_in = rsp_ff;
      rspv_in = 1'b0;
      div_req = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !rspv_ff) begin
               req_in = req_data;
               rsp_in = '0;
               state_in = (req_data.op == OpWrite) ? S_WR : S_DIVX;
               if (req_data.op == OpRay) begin
                  div_req.start = 1'b1;
                  div_req.num = {24'b0, req_data.start_x[23] ? 24'(-req_data.start_x)
                                                               : req_data.start_x};
                  div_req.den = {8'b0, ((ps_ff == 16'd0) ? 16'd1 : ps_ff)};
               end
            end
         end
         S_WR: begin
            rsp_in.status = StatusWrite;
            state_in = S_OUT;
         end
         S_DIVX: begin
            if (div_rsp.done) begin
               cx_in = q_floor;
               ox_in = off_start;
               div_req.start = 1'b1;
               div_req.num = {24'b0, req_ff.start_y[23] ? 24'(-req_ff.start_y)
                                                          : req_ff.start_y};
               div_req.den = {8'b0, ps_eff};
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_rsp.done) begin
               cy_in = q_floor;
               oy_in = off_start;
               nb_in = 3'd0;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (zero_dir) begin
               rsp_in.status = StatusZero;
               state_in = S_OUT;
            end else if (cx_ff[25] || cy_ff[25] || cx_ff >= $signed({15'b0, ew})
                         || cy_ff >= $signed({15'b0, eh})) begin
               rsp_in.status = StatusLeft;
               state_in = S_OUT;
            end else begin
               nb_in = 3'd0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            // outside cells are filled without a map read
            if (out_cell) begin
               if (nb_ff == 3'd4) state_in = S_STEP;
               else nb_in = nb_ff + 3'd1;
            end else begin
               state_in = S_RDW;
            end
         end
         S_RDW: begin
            if (nb_ff == 3'd0) begin
               if (!rd_data) state_in = S_STEP;
               else begin
                  nb_in = 3'd1;
                  state_in = S_RD;
               end
            end else if (!rd_data) begin
               rsp_in.status = StatusEdge;
               rsp_in.end_x = cx_ff[6:0];
               rsp_in.end_y = cy_ff[6:0];
               state_in = S_OUT;
            end else if (nb_ff == 3'd4) begin
               state_in = S_STEP;
            end else begin
               nb_in = nb_ff + 3'd1;
               state_in = S_RD;
            end
         end
         S_STEP: begin
            // two multiplies, one per cycle
            if (!mulph_ff) begin
               prodx_in = 48'(xd) * 48'(ay);
               mulph_in = 1'b1;
            end else begin
               prody_in = 48'(yd) * 48'(ax);
               mulph_in = 1'b0;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            stepx_in = (req_ff.dir_x != '0) &&
                       ((req_ff.dir_y == '0) || (prodx_ff <= prody_ff));
            div_req.start = 1'b1;
            if ((req_ff.dir_x != '0) &&
                ((req_ff.dir_y == '0) || (prodx_ff <= prody_ff))) begin
               div_req.num = prodx_ff;
               div_req.den = ax;
            end else begin
               div_req.num = prody_ff;
               div_req.den = ay;
            end
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               if (stepx_ff) begin
                  if (req_ff.dir_y[23]) oy_in = oy_ff - div_rsp.quo[24:0];
                  else oy_in = oy_ff + div_rsp.quo[24:0];
                  if (req_ff.dir_x[23]) begin
                     cx_in = cx_ff - 26'sd1; ox_in = psq;
                  end else begin
                     cx_in = cx_ff + 26'sd1; ox_in = '0;
                  end
               end else begin
                  if (req_ff.dir_x[23]) ox_in = ox_ff - div_rsp.quo[24:0];
                  else ox_in = ox_ff + div_rsp.quo[24:0];
                  if (req_ff.dir_y[23]) begin
                     cy_in = cy_ff - 26'sd1; oy_in = psq;
                  end else begin
                     cy_in = cy_ff + 26'sd1; oy_in = '0;
                  end
               end
               state_in = S_CHK;
            end
         end
         S_OUT: begin
            rspv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cx_ff <= cx_in; cy_ff <= cy_in; ox_ff <= ox_in; oy_ff <= oy_in;
      nb_ff <= nb_in; stepx_ff <= stepx_in;
      prodx_ff <= prodx_in; prody_ff <= prody_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rspv_ff  <= 1'b0;
         mulph_ff <= 1'b0;
         gw_ff <= 8'd100;
         gh_ff <= 8'd100;
         ps_ff <= 16'd256;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
         mulph_ff <= mulph_in;
         if (csr_valid) begin
            if (csr_index == CsrGridWidth) gw_ff <= csr_data[7:0];
            if (csr_index == CsrGridHeight) gh_ff <= csr_data[7:0];
            if (csr_index == CsrPixelSize) ps_ff <= csr_data;
         end
      end
   end

   assign busy      = (state_ff != S_IDLE) || rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

endmodule
